### design/curve_cell_stack_select_top_defines.svh
// assertion macros for the curve cell stack select checker
`ifndef CURVE_CELL_STACK_SELECT_TOP_DEFINES_SVH
`define CURVE_CELL_STACK_SELECT_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define CCSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define CCSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ccss_pkg.sv
// shared constants and item types for the curve cell stack selector
package ccss_pkg;

  localparam int DIMENSIONS  = 3;
  localparam int BASE_STACKS = 3;

  localparam int AXIS_BITS  = 3;
  localparam int FACE_SLOTS = 6;
  localparam int ACCESS_W   = 4;
  localparam int FACE_W     = $clog2(2 * DIMENSIONS);
  localparam int STACK_W    = 4;
  localparam int SUM_W      = 6;

  localparam logic [1:0] CELL_STACK_A = 2'd1;
  localparam logic [1:0] CELL_STACK_B = 2'd2;

  typedef struct packed {
    logic [2:0]                     even_flags;
    logic                           inverted;
    logic [FACE_SLOTS*ACCESS_W-1:0] face_access;
    logic [2:0]                     vertex_index;
    logic [2:0]                     face_index;
  } in_item_t;

  typedef struct packed {
    logic [STACK_W-1:0] vertex_read_stack;
    logic [STACK_W-1:0] vertex_write_stack;
    logic [STACK_W-1:0] face_read_stack;
    logic [STACK_W-1:0] face_write_stack;
    logic [1:0]         cell_read_stack;
    logic [1:0]         cell_write_stack;
    logic [2:0]         loop_direction;
    logic [2:0]         first_vertex;
    logic [2:0]         face_along_curve;
  } out_item_t;

endpackage

### design/curve_cell_stack_select_top.sv
// curve cell stack selector: input register, selection logic, result register
//
//   channel | handshake                 | payload
//   in      | in_valid_i / in_ready_o   | in_item_i  (ccss_pkg::in_item_t)
//   out     | out_valid_o / out_ready_i | out_item_o (ccss_pkg::out_item_t)
//
// one item per cycle unless the output stalls; an accepted item passes through
// the input register and then the result register, which are the only stages
// a stalled result holds in the result register while one more item waits
// in the input register; reset empties both stages
module curve_cell_stack_select_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ccss_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccss_pkg::out_item_t out_item_o
);
  import ccss_pkg::*;

  localparam int D = DIMENSIONS;
  localparam int FA_W = FACE_SLOTS * ACCESS_W + 2 * D * ACCESS_W;
  localparam logic signed [SUM_W-1:0] READ_LIMIT  = SUM_W'(-(2 * D + 1));
  localparam logic signed [SUM_W-1:0] WRITE_LIMIT = SUM_W'(2 * D + 1);
  localparam logic [STACK_W-1:0] STACK_M1 = STACK_W'(BASE_STACKS - 1);
  localparam logic [STACK_W-1:0] STACK_M2 = STACK_W'(BASE_STACKS - 2);

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t out_item_d;
  logic      stage_adv;

  function automatic logic [FACE_W-1:0] mirror_face(input logic [FACE_W-1:0] f);
    logic [FACE_W-1:0] r;
    if (SUM_W'(f) < SUM_W'(D)) begin
      r = FACE_W'(SUM_W'(f) + SUM_W'(D));
    end else begin
      r = FACE_W'(SUM_W'(f) - SUM_W'(D));
    end
    return r;
  endfunction

  function automatic logic [STACK_W-1:0] vertex_stack(
    input logic [D+2:0]    ev,
    input logic            inv,
    input logic [FA_W-1:0] fa,
    input logic [D+2:0]    vtx,
    input logic            rd
  );
    logic signed [SUM_W-1:0] best;
    logic signed [SUM_W-1:0] a;
    logic [ACCESS_W-1:0]     nib;
    logic [FACE_W-1:0]       f;
    logic [FACE_W-1:0]       sel;
    logic                    found;
    logic                    sel_even;
    logic                    take;
    logic [STACK_W-1:0]      stack;
    best     = rd ? READ_LIMIT : WRITE_LIMIT;
    found    = 1'b0;
    sel      = '0;
    sel_even = 1'b0;
    for (int d = 0; d < D; d++) begin
      f    = vtx[d] ? FACE_W'(d + D) : FACE_W'(d);
      nib  = fa[ACCESS_W*f +: ACCESS_W];
      a    = {{(SUM_W-ACCESS_W){nib[ACCESS_W-1]}}, nib};
      take = rd ? (a < 0 && a > best) : (a > 0 && a < best);
      if (take) begin
        found    = 1'b1;
        sel      = f;
        best     = a;
        sel_even = ev[d];
      end
    end
    if (found) begin
      if (sel_even) begin
        sel = mirror_face(sel);
      end
      stack = STACK_W'(SUM_W'(sel) + SUM_W'(BASE_STACKS));
    end else begin
      stack = (rd == inv) ? STACK_M1 : STACK_M2;
    end
    return stack;
  endfunction

  function automatic logic [STACK_W-1:0] face_stack(
    input logic [D+2:0]      ev,
    input logic              inv,
    input logic [FA_W-1:0]   fa,
    input logic [FACE_W-1:0] f,
    input logic              rd
  );
    logic [ACCESS_W-1:0] nib;
    logic [FACE_W-1:0]   norm;
    logic [SUM_W-1:0]    sum;
    logic                hit;
    logic [STACK_W-1:0]  stack;
    nib  = fa[ACCESS_W*f +: ACCESS_W];
    hit  = rd ? nib[ACCESS_W-1] : (nib != '0 && !nib[ACCESS_W-1]);
    norm = (SUM_W'(f) < SUM_W'(D)) ? f : FACE_W'(SUM_W'(f) - SUM_W'(D));
    sum  = SUM_W'(f) + (inv ? SUM_W'(D) : '0) + (ev[norm] ? SUM_W'(D) : '0);
    if (sum >= SUM_W'(2 * D)) begin
      sum = sum - SUM_W'(2 * D);
    end
    if (hit) begin
      stack = STACK_W'(sum + SUM_W'(BASE_STACKS));
    end else begin
      stack = (rd == inv) ? STACK_M2 : STACK_M1;
    end
    return stack;
  endfunction

  always_comb begin
    logic [D+2:0]      ev;
    logic [D+2:0]      vtx;
    logic [FA_W-1:0]   fa;
    logic [FACE_W-1:0] fidx;
    logic [FACE_W-1:0] cf;
    logic [FACE_W-1:0] normal;
    logic [D-1:0]      fv;
    logic [D+2:0]      fv_x;
    logic [2:0]        dir;
    logic              par;
    logic              inv;
    inv  = in_q.inverted;
    ev   = {{D{1'b0}}, in_q.even_flags};
    vtx  = {{D{1'b0}}, in_q.vertex_index};
    fa   = {{(2*D*ACCESS_W){1'b0}}, in_q.face_access};
    if ((SUM_W'(in_q.face_index)) >= SUM_W'(2 * D)) begin
      fidx = FACE_W'(SUM_W'(in_q.face_index) - SUM_W'(2 * D));
    end else begin
      fidx = FACE_W'(in_q.face_index);
    end

    dir = '0;
    for (int d = 0; d < AXIS_BITS; d++) begin
      if (d < D) begin
        par = 1'b0;
        for (int e = 0; e < D; e++) begin
          if (e != d) begin
            par = par ^ ev[e];
          end
        end
        dir[d] = ~par ^ inv;
      end
    end

    fv = '0;
    for (int d = 0; d < D; d++) begin
      if (ev[d]) begin
        fv = fv ^ ~(D'(1) << d);
      end
    end
    if (inv) begin
      fv = ~fv;
    end
    fv_x = {3'b000, fv};

    cf     = inv ? FACE_W'(SUM_W'(2 * D - 1) - SUM_W'(fidx)) : fidx;
    normal = (SUM_W'(cf) < SUM_W'(D)) ? cf : FACE_W'(SUM_W'(cf) - SUM_W'(D));
    par    = 1'b0;
    for (int d = 0; d < D; d++) begin
      if (FACE_W'(d) != normal) begin
        par = par ^ ev[d];
      end
    end

    out_item_d.vertex_read_stack  = vertex_stack(ev, inv, fa, vtx, 1'b1);
    out_item_d.vertex_write_stack = vertex_stack(ev, inv, fa, vtx, 1'b0);
    out_item_d.face_read_stack    = face_stack(ev, inv, fa, fidx, 1'b1);
    out_item_d.face_write_stack   = face_stack(ev, inv, fa, fidx, 1'b0);
    out_item_d.cell_read_stack    = inv ? CELL_STACK_A : CELL_STACK_B;
    out_item_d.cell_write_stack   = inv ? CELL_STACK_B : CELL_STACK_A;
    out_item_d.loop_direction     = dir;
    out_item_d.first_vertex       = fv_x[2:0];
    out_item_d.face_along_curve   = 3'(par ? mirror_face(cf) : cf);
  end

  assign stage_adv  = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || stage_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (stage_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (in_valid_q && stage_adv) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### design/ccss_checker.sv
// port checker for the curve cell stack selector, bound to the top level
`include "curve_cell_stack_select_top_defines.svh"

module ccss_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input ccss_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ccss_pkg::out_item_t out_item_o
);
  import ccss_pkg::*;

  `CCSS_ASSERT_NOW(a_cell_stacks_differ, out_valid_o,
    (out_item_o.cell_read_stack == CELL_STACK_A &&
     out_item_o.cell_write_stack == CELL_STACK_B) ||
    (out_item_o.cell_read_stack == CELL_STACK_B &&
     out_item_o.cell_write_stack == CELL_STACK_A),
    "cell read and write stacks not a complementary pair")

  `CCSS_ASSERT_NOW(a_face_along_range, out_valid_o,
    {1'b0, out_item_o.face_along_curve} < 4'(2 * DIMENSIONS),
    "face along curve out of range")

  `CCSS_ASSERT_NOW(a_ready_when_out_empty, !out_valid_o, in_ready_o,
    "input stalled while result register is empty")

  `CCSS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_item_o),
    "stalled result item dropped or changed")

  `CCSS_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o,
    in_valid_i && $stable(in_item_i),
    "waiting input item dropped or changed")

endmodule

bind curve_cell_stack_select_top ccss_checker u_ccss_checker (.*);

### tb/ccss_stack_checker.sv
// channel monitor, stack predictor and result comparison for the curve cell stack selector
module ccss_stack_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ccss_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ccss_pkg::out_item_t out_item_i,
  output int                  outstanding_o,
  output int                  mismatches_o
);
  import ccss_pkg::*;

  localparam int PRINT_CAP = 100;

  out_item_t expected_stacks[$];
  int        mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] stack mismatch: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  function automatic int even_bit(input logic [2:0] flags, input int d);
    if (d < 0 || d >= AXIS_BITS) return 0;
    return int'(flags[d]);
  endfunction

  function automatic int access_num(input logic [FACE_SLOTS*ACCESS_W-1:0] fa, input int f);
    logic signed [ACCESS_W-1:0] nib;
    if (f < 0 || f >= FACE_SLOTS) return 0;
    nib = fa[f*ACCESS_W +: ACCESS_W];
    return int'(nib);
  endfunction

  function automatic logic [STACK_W-1:0] vertex_stack(input in_item_t it, input bit reading);
    int best;
    int res;
    int axis;
    int f;
    int a;
    bit take;
    best = reading ? -2 * DIMENSIONS - 1 : 2 * DIMENSIONS + 1;
    if (reading) res = it.inverted ? -1 : -2;
    else res = it.inverted ? -2 : -1;
    axis = -1;
    for (int d = 0; d < DIMENSIONS; d++) begin
      f = even_bit(it.vertex_index, d) ? d + DIMENSIONS : d;
      a = access_num(it.face_access, f);
      take = reading ? (a < 0 && a > best) : (a > 0 && a < best);
      if (take) begin
        res  = f;
        best = a;
        axis = d;
      end
    end
    if (axis >= 0 && even_bit(it.even_flags, axis) != 0) begin
      res = (res < DIMENSIONS) ? res + DIMENSIONS : res - DIMENSIONS;
    end
    return STACK_W'(res + BASE_STACKS);
  endfunction

  function automatic logic [STACK_W-1:0] face_stack(input in_item_t it, input int f,
                                                    input bit reading);
    int a;
    int res;
    a = access_num(it.face_access, f);
    if (reading) res = it.inverted ? -2 : -1;
    else res = it.inverted ? -1 : -2;
    if (reading ? (a < 0) : (a > 0)) begin
      res = f;
      if (it.inverted) res += DIMENSIONS;
      if (even_bit(it.even_flags, f % DIMENSIONS) != 0) res += DIMENSIONS;
      res = res % (2 * DIMENSIONS);
    end
    return STACK_W'(res + BASE_STACKS);
  endfunction

  function automatic out_item_t predict_stacks(input in_item_t it);
    out_item_t  r;
    int         f;
    int         cnt;
    int         cf;
    int         normal;
    int         along;
    logic [2:0] dir;
    logic [2:0] first;
    logic [2:0] all_axes;
    f        = int'(it.face_index) % (2 * DIMENSIONS);
    dir      = '0;
    first    = '0;
    all_axes = 3'((1 << DIMENSIONS) - 1);
    for (int d = 0; d < DIMENSIONS; d++) begin
      cnt = 0;
      for (int e = 0; e < DIMENSIONS; e++) begin
        if (e != d && even_bit(it.even_flags, e) != 0) cnt++;
      end
      if (((cnt % 2) == 0) != (it.inverted == 1'b1)) dir[d] = 1'b1;
      if (even_bit(it.even_flags, d) != 0) first ^= all_axes & ~(3'b001 << d);
    end
    if (it.inverted) first ^= all_axes;

    cf     = it.inverted ? 2 * DIMENSIONS - 1 - f : f;
    normal = cf % DIMENSIONS;
    along  = cf;
    for (int d = 0; d < DIMENSIONS; d++) begin
      if (d != normal && even_bit(it.even_flags, d) != 0) along += DIMENSIONS;
    end
    along = along % (2 * DIMENSIONS);

    r.vertex_read_stack  = vertex_stack(it, 1'b1);
    r.vertex_write_stack = vertex_stack(it, 1'b0);
    r.face_read_stack    = face_stack(it, f, 1'b1);
    r.face_write_stack   = face_stack(it, f, 1'b0);
    r.cell_read_stack    = it.inverted ? CELL_STACK_A : CELL_STACK_B;
    r.cell_write_stack   = it.inverted ? CELL_STACK_B : CELL_STACK_A;
    r.loop_direction     = dir;
    r.first_vertex       = first;
    r.face_along_curve   = 3'(along);
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        got = out_item_i;
        if (expected_stacks.size() == 0) begin
          report_mismatch($sformatf("unexpected item %h", got));
        end else begin
          want = expected_stacks.pop_front();
          if (got.vertex_read_stack !== want.vertex_read_stack)
            report_mismatch($sformatf("vertex_read_stack got %0d want %0d",
                                      got.vertex_read_stack, want.vertex_read_stack));
          if (got.vertex_write_stack !== want.vertex_write_stack)
            report_mismatch($sformatf("vertex_write_stack got %0d want %0d",
                                      got.vertex_write_stack, want.vertex_write_stack));
          if (got.face_read_stack !== want.face_read_stack)
            report_mismatch($sformatf("face_read_stack got %0d want %0d",
                                      got.face_read_stack, want.face_read_stack));
          if (got.face_write_stack !== want.face_write_stack)
            report_mismatch($sformatf("face_write_stack got %0d want %0d",
                                      got.face_write_stack, want.face_write_stack));
          if (got.cell_read_stack !== want.cell_read_stack)
            report_mismatch($sformatf("cell_read_stack got %0d want %0d",
                                      got.cell_read_stack, want.cell_read_stack));
          if (got.cell_write_stack !== want.cell_write_stack)
            report_mismatch($sformatf("cell_write_stack got %0d want %0d",
                                      got.cell_write_stack, want.cell_write_stack));
          if (got.loop_direction !== want.loop_direction)
            report_mismatch($sformatf("loop_direction got %b want %b",
                                      got.loop_direction, want.loop_direction));
          if (got.first_vertex !== want.first_vertex)
            report_mismatch($sformatf("first_vertex got %b want %b",
                                      got.first_vertex, want.first_vertex));
          if (got.face_along_curve !== want.face_along_curve)
            report_mismatch($sformatf("face_along_curve got %0d want %0d",
                                      got.face_along_curve, want.face_along_curve));
        end
      end
      if (in_valid_i && in_ready_i) begin
        expected_stacks.push_back(predict_stacks(in_item_i));
      end
      outstanding_o <= expected_stacks.size();
    end
  end

endmodule

### tb/curve_cell_stack_select_top_tb.sv
// stimulus, handshake pacing and verdict for the curve cell stack selector
module curve_cell_stack_select_top_tb;
  import ccss_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 225;
  localparam int TAIL_CYCLES = 10;
  localparam int PHASES      = 4;

  localparam int SEND_IDLE[PHASES]  = '{0, 48, 0, 19};
  localparam int RECV_STALL[PHASES] = '{0, 0, 48, 19};

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  int outstanding;
  int mismatches;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_count    = 0;

  curve_cell_stack_select_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  ccss_stack_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_item_i     (in_item_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_i    (out_item_o),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("curve_cell_stack_select_top_tb: errors");
    $finish;
  end

  // result side backpressure
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic in_item_t cell_item(input logic [2:0] even, input logic inv,
                                         input logic [23:0] fa, input logic [2:0] vtx,
                                         input logic [2:0] face);
    in_item_t it;
    it.even_flags   = even;
    it.inverted     = inv;
    it.face_access  = fa;
    it.vertex_index = vtx;
    it.face_index   = face;
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  initial begin
    in_item_t            it;
    logic [23:0]         fa;
    logic [ACCESS_W-1:0] same_nib;
    int                  mode;

    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes, ties, unreachable access numbers, faces above range
    send_item(cell_item(3'd0, 1'b0, 24'h000000, 3'd0, 3'd0));
    send_item(cell_item(3'd7, 1'b1, 24'hFFFFFF, 3'd7, 3'd5));
    send_item(cell_item(3'd0, 1'b0, 24'h888888, 3'd0, 3'd1));
    send_item(cell_item(3'd0, 1'b1, 24'h999999, 3'd7, 3'd2));
    send_item(cell_item(3'd7, 1'b0, 24'h777777, 3'd0, 3'd3));
    send_item(cell_item(3'd5, 1'b1, 24'h666666, 3'd5, 3'd4));
    send_item(cell_item(3'd2, 1'b0, 24'hAAAAAA, 3'd2, 3'd6));
    send_item(cell_item(3'd3, 1'b1, 24'h123456, 3'd3, 3'd7));
    send_item(cell_item(3'd1, 1'b0, 24'h000FFF, 3'd0, 3'd0));
    send_item(cell_item(3'd4, 1'b1, 24'h111000, 3'd7, 3'd3));
    send_item(cell_item(3'd6, 1'b0, 24'hF1E2D3, 3'd4, 3'd2));
    send_item(cell_item(3'd1, 1'b1, 24'h1F1F1F, 3'd1, 3'd1));
    send_item(cell_item(3'd2, 1'b1, 24'hF1F1F1, 3'd6, 3'd5));
    send_item(cell_item(3'd4, 1'b0, 24'h8F7181, 3'd3, 3'd0));
    send_item(cell_item(3'd7, 1'b0, 24'h000000, 3'd7, 3'd7));
    send_item(cell_item(3'd0, 1'b1, 24'hFFFFFF, 3'd0, 3'd6));
    send_item(cell_item(3'd5, 1'b0, 24'h7E7E7E, 3'd2, 3'd4));
    send_item(cell_item(3'd3, 1'b0, 24'h9A9A9A, 3'd5, 3'd3));
    send_item(cell_item(3'd6, 1'b1, 24'h2E2E2E, 3'd6, 3'd6));
    send_item(cell_item(3'd7, 1'b1, 24'h8181F7, 3'd1, 3'd7));
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_results();
        mode     = $urandom_range(3);
        same_nib = ACCESS_W'($urandom_range(15));
        fa       = 24'($urandom());
        for (int k = 0; k < FACE_SLOTS; k++) begin
          case (mode)
            1: begin
              fa[k*ACCESS_W +: ACCESS_W] = same_nib;
            end
            2: begin
              fa[k*ACCESS_W +: ACCESS_W] = ACCESS_W'($urandom_range(4) - 2);
            end
            3: begin
              fa[k*ACCESS_W +: ACCESS_W] = ACCESS_W'(4'h5 + $urandom_range(5));
            end
            default: begin
            end
          endcase
        end
        it = cell_item(3'($urandom_range(7)), 1'($urandom_range(1)), fa,
                       3'($urandom_range(7)), 3'($urandom_range(7)));
        send_item(it);
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("curve_cell_stack_select_top_tb: clean");
    end else begin
      $display("curve_cell_stack_select_top_tb: errors");
    end
    $finish;
  end

endmodule

### curve_cell_stack_select_top.f
+incdir+design
design/ccss_pkg.sv
design/curve_cell_stack_select_top.sv
design/ccss_checker.sv
tb/ccss_stack_checker.sv
tb/curve_cell_stack_select_top_tb.sv
